// ----- rtl/core/ecc_point_arithmetic_top_assert.svh -----
// assertion macros for the elliptic-curve point arithmetic block
// expects signals clk and rst in the scope of the including module
`ifndef ECC_POINT_ARITHMETIC_TOP_ASSERT_SVH
`define ECC_POINT_ARITHMETIC_TOP_ASSERT_SVH

// same-cycle implication
`define ECPA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ECPA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ecpa_pkg.sv -----
// shared types and constants for the elliptic-curve point arithmetic block
// no dependencies
package ecpa_pkg;

  localparam int FLD_W      = 32;
  localparam int IN_DATA_W  = 160;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 2;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_W-1:0] PRIME_RESET = 32'd23;
  localparam logic [CFG_W-1:0] A_RESET     = 32'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRIME = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_A     = 1'b1;

  // action codes
  localparam logic [1:0] ACT_MUL = 2'd0;
  localparam logic [1:0] ACT_ADD = 2'd1;
  localparam logic [1:0] ACT_SUB = 2'd2;

  // modular unit operations
  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_MUL = 2'd2;
  localparam logic [1:0] ALU_INV = 2'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic fail;
  } op_stat_t;

endpackage

// ----- rtl/core/ecc_point_arithmetic_top.sv -----
// each transaction first reduces its operands modulo the prime, then runs
// point operations, an addition taking one extended euclidean inverse when it
// needs a slope; scalar multiply does up to 2*SCALAR_BITS-1 such operations; one
// transaction at a time, all of it on one shared modular unit. synchronous reset
// clears control and sets field_prime to 23 and curve_a to 1
`include "ecc_point_arithmetic_top_assert.svh"
module ecc_point_arithmetic_top #(
  parameter int FIELD_BITS  = 32,
  parameter int SCALAR_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // first_x, first_y, second_x, second_y, scalar
  input  logic [ecpa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // action[1:0], first_is_infinity, second_is_infinity
  input  logic [ecpa_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // result_x, result_y
  output logic [ecpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // result_is_infinity, inverse_failed
  output logic [ecpa_pkg::OUT_USER_W-1:0] m_axis_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ecpa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecpa_pkg::CFG_W-1:0]      cfg_data
);
  import ecpa_pkg::*;

  localparam int W = FIELD_BITS;

  localparam logic [3:0] T_IDLE = 4'd0;
  localparam logic [3:0] T_RGO  = 4'd1;
  localparam logic [3:0] T_RW   = 4'd2;
  localparam logic [3:0] T_DISP = 4'd3;
  localparam logic [3:0] T_NGO  = 4'd4;
  localparam logic [3:0] T_NW   = 4'd5;
  localparam logic [3:0] T_SCHK = 4'd6;
  localparam logic [3:0] T_SSH  = 4'd7;
  localparam logic [3:0] T_PGO  = 4'd8;
  localparam logic [3:0] T_PW   = 4'd9;
  localparam logic [3:0] T_FIN  = 4'd10;

  localparam logic [1:0] M_RU = 2'd0;
  localparam logic [1:0] M_UU = 2'd1;
  localparam logic [1:0] M_UV = 2'd2;

  localparam logic [2:0] RED_LAST = 3'd4;

  logic [3:0]             st;
  logic [CFG_W-1:0]       cprime, cfga;
  logic [W-1:0]           pw, wa, ux, uy, vx, vy, rx, ry;
  logic                   uinf, vinf, rinf, fl;
  logic [1:0]             act, mode;
  logic [SCALAR_BITS-1:0] k, kshift;
  logic [2:0]             ridx;
  logic [W-1:0]           redval;
  logic                   out_inf;

  alu_req_t     top_req, pa_req, alu_req;
  op_stat_t     alu_stat, pa_stat;
  logic [W-1:0] top_a, top_b, pa_a, pa_b, alu_a, alu_b, alu_res;
  logic [W-1:0] pux, puy, pvx, pvy, prx, pry;
  logic         puinf, pvinf, prinf, pa_start;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (st == T_IDLE);
  assign kshift        = k >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cprime <= PRIME_RESET;
      cfga   <= A_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRIME: cprime <= cfg_data;
        REG_A:     cfga   <= cfg_data;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      3'd0:    redval = wa;
      3'd1:    redval = ux;
      3'd2:    redval = uy;
      3'd3:    redval = vx;
      default: redval = vy;
    endcase
  end

  // reduction is a multiply by one, negation a subtract from zero
  always_comb begin
    top_req.start = (st == T_RGO) || (st == T_NGO);
    top_req.op    = (st == T_RGO) ? ALU_MUL : ALU_SUB;
    top_a         = (st == T_RGO) ? W'(1) : '0;
    top_b         = (st == T_RGO) ? redval : vy;
  end

  assign alu_req = (st == T_PW) ? pa_req : top_req;
  assign alu_a   = (st == T_PW) ? pa_a : top_a;
  assign alu_b   = (st == T_PW) ? pa_b : top_b;

  always_comb begin
    case (mode)
      M_RU: begin
        pux = rx; puy = ry; puinf = rinf;
        pvx = ux; pvy = uy; pvinf = uinf;
      end
      M_UU: begin
        pux = ux; puy = uy; puinf = uinf;
        pvx = ux; pvy = uy; pvinf = uinf;
      end
      default: begin
        pux = ux; puy = uy; puinf = uinf;
        pvx = vx; pvy = vy; pvinf = vinf;
      end
    endcase
  end

  assign pa_start = (st == T_PGO);

  ecpa_modalu #(.W(W)) u_alu (
    .clk  (clk),
    .rst  (rst),
    .req  (alu_req),
    .opa  (alu_a),
    .opb  (alu_b),
    .p    (pw),
    .res  (alu_res),
    .stat (alu_stat)
  );

  ecpa_ptadd #(.W(W)) u_ptadd (
    .clk   (clk),
    .rst   (rst),
    .start (pa_start),
    .ux    (pux),
    .uy    (puy),
    .uinf  (puinf),
    .vx    (pvx),
    .vy    (pvy),
    .vinf  (pvinf),
    .ca    (wa),
    .areq  (pa_req),
    .opa   (pa_a),
    .opb   (pa_b),
    .ares  (alu_res),
    .astat (alu_stat),
    .rx    (prx),
    .ry    (pry),
    .rinf  (prinf),
    .stat  (pa_stat)
  );

  assign out_inf = fl | rinf;

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= T_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && st != T_FIN) m_axis_tvalid <= 1'b0;
      unique case (st)
        T_IDLE: begin
          if (s_axis_tvalid) begin
            act  <= s_axis_tuser[1:0];
            uinf <= s_axis_tuser[2];
            vinf <= s_axis_tuser[3];
            ux   <= W'(s_axis_tdata[31:0]);
            uy   <= W'(s_axis_tdata[63:32]);
            vx   <= W'(s_axis_tdata[95:64]);
            vy   <= W'(s_axis_tdata[127:96]);
            k    <= SCALAR_BITS'(s_axis_tdata[159:128]);
            wa   <= W'(cfga);
            pw   <= W'(cprime);
            rinf <= 1'b1;
            ridx <= '0;
            // no field below two
            if (W'(cprime) < W'(2)) begin
              fl <= 1'b1;
              st <= T_FIN;
            end else begin
              fl <= 1'b0;
              st <= T_RGO;
            end
          end
        end
        T_RGO: st <= T_RW;
        T_RW: begin
          if (alu_stat.done) begin
            case (ridx)
              3'd0:    wa <= alu_res;
              3'd1:    ux <= alu_res;
              3'd2:    uy <= alu_res;
              3'd3:    vx <= alu_res;
              default: vy <= alu_res;
            endcase
            ridx <= ridx + 1'b1;
            st   <= (ridx == RED_LAST) ? T_DISP : T_RGO;
          end
        end
        T_DISP: begin
          mode <= M_UV;
          unique case (act)
            ACT_MUL: st <= T_SCHK;
            ACT_ADD: st <= T_PGO;
            ACT_SUB: st <= T_NGO;
            default: st <= T_FIN;
          endcase
        end
        T_NGO: st <= T_NW;
        T_NW: begin
          if (alu_stat.done) begin
            vy <= alu_res;
            st <= T_PGO;
          end
        end
        T_SCHK: begin
          if (k == '0) begin
            st <= T_FIN;
          end else if (k[0]) begin
            mode <= M_RU;
            st   <= T_PGO;
          end else begin
            st <= T_SSH;
          end
        end
        T_SSH: begin
          k <= kshift;
          // no doubling after the top set bit
          if (kshift != '0) begin
            mode <= M_UU;
            st   <= T_PGO;
          end else begin
            st <= T_FIN;
          end
        end
        T_PGO: st <= T_PW;
        T_PW: begin
          if (pa_stat.done) begin
            fl <= pa_stat.fail;
            case (mode)
              M_RU: begin
                rx   <= prx;
                ry   <= pry;
                rinf <= prinf;
                st   <= pa_stat.fail ? T_FIN : T_SSH;
              end
              M_UU: begin
                ux   <= prx;
                uy   <= pry;
                uinf <= prinf;
                st   <= pa_stat.fail ? T_FIN : T_SCHK;
              end
              default: begin
                rx   <= prx;
                ry   <= pry;
                rinf <= prinf;
                st   <= T_FIN;
              end
            endcase
          end
        end
        T_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid     <= 1'b1;
            m_axis_tdata      <= out_inf ? '0 : {FLD_W'(ry), FLD_W'(rx)};
            m_axis_tuser      <= {fl, out_inf};
            st                <= T_IDLE;
          end
        end
        default: st <= T_IDLE;
      endcase
    end
  end

  `ECPA_ASSERT_IMP(a_fail_inf, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0], "inverse failure must give infinity")
  `ECPA_ASSERT_IMP(a_inf_zero, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0, "infinity must carry zero coordinates")
  `ECPA_ASSERT_NXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accepted a transaction while busy")
  `ECPA_ASSERT_IMP(a_reduced, st == T_PW, ux < pw && vx < pw, "point operand not reduced")

endmodule

// ----- rtl/core/ecpa_modalu.sv -----
// shared modular arithmetic unit: add, subtract, bit-serial multiply and
// extended euclidean inverse with a restoring divider; uses ecpa_pkg
module ecpa_modalu #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  ecpa_pkg::alu_req_t req,
  input  logic [W-1:0]       opa,
  input  logic [W-1:0]       opb,
  input  logic [W-1:0]       p,
  output logic [W-1:0]       res,
  output ecpa_pkg::op_stat_t stat
);
  import ecpa_pkg::*;

  localparam int CW = $clog2(W);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ITST = 3'd2;
  localparam logic [2:0] S_IDIV = 3'd3;
  localparam logic [2:0] S_IUPD = 3'd4;

  logic [2:0]    st;
  logic [CW-1:0] cnt;
  logic [W-1:0]  ma, mb, acc, r0, r1, t0, t1, rem;
  logic          done, fail, done_next;
  logic [W-1:0]  acc_dbl, addend, acc_next;
  logic [W:0]    remsh, remdf;
  logic          qb, take;

  function automatic logic [W-1:0] madd(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] m);
    logic [W-1:0] d;
    d = m - y;
    return (x >= d) ? x - d : x + y;
  endfunction

  function automatic logic [W-1:0] msub(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] m);
    return (x >= y) ? x - y : x + (m - y);
  endfunction

  always_comb begin
    acc_dbl  = madd(acc, acc, p);
    remsh    = {rem, r0[cnt]};
    remdf    = remsh - {1'b0, r1};
    qb       = remsh >= {1'b0, r1};
    // multiply takes multiplier bits, inverse takes quotient bits msb first
    addend   = (st == S_MUL) ? ma : t1;
    take     = (st == S_MUL) ? mb[cnt] : qb;
    acc_next = take ? madd(acc_dbl, addend, p) : acc_dbl;
    done_next = ((st == S_IDLE) && req.start && ((req.op == ALU_ADD) || (req.op == ALU_SUB)))
             || ((st == S_MUL) && (cnt == '0))
             || ((st == S_ITST) && (r1 == '0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= done_next;
      unique case (st)
        S_IDLE: begin
          if (req.start) begin
            unique case (req.op)
              ALU_ADD: begin
                res  <= madd(opa, opb, p);
                fail <= 1'b0;
              end
              ALU_SUB: begin
                res  <= msub(opa, opb, p);
                fail <= 1'b0;
              end
              ALU_MUL: begin
                ma  <= opa;
                mb  <= opb;
                acc <= '0;
                cnt <= CW'(W - 1);
                st  <= S_MUL;
              end
              ALU_INV: begin
                r0 <= p;
                r1 <= opa;
                t0 <= '0;
                t1 <= W'(1);
                st <= S_ITST;
              end
            endcase
          end
        end
        S_MUL: begin
          acc <= acc_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) begin
            res  <= acc_next;
            fail <= 1'b0;
            st   <= S_IDLE;
          end
        end
        S_ITST: begin
          if (r1 == '0) begin
            res  <= t0;
            fail <= (r0 != W'(1));
            st   <= S_IDLE;
          end else begin
            rem <= '0;
            acc <= '0;
            cnt <= CW'(W - 1);
            st  <= S_IDIV;
          end
        end
        S_IDIV: begin
          rem <= qb ? remdf[W-1:0] : remsh[W-1:0];
          acc <= acc_next;
          cnt <= cnt - 1'b1;
          if (cnt == '0) st <= S_IUPD;
        end
        S_IUPD: begin
          r0 <= r1;
          r1 <= rem;
          t0 <= t1;
          t1 <= msub(t0, acc, p);
          st <= S_ITST;
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  assign stat.done = done;
  assign stat.fail = fail;

endmodule

// ----- rtl/core/ecpa_ptadd.sv -----
// affine point addition sequencer, issues steps to the shared modular unit
// uses ecpa_pkg
module ecpa_ptadd #(
  parameter int W = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [W-1:0]       ux,
  input  logic [W-1:0]       uy,
  input  logic               uinf,
  input  logic [W-1:0]       vx,
  input  logic [W-1:0]       vy,
  input  logic               vinf,
  input  logic [W-1:0]       ca,
  output ecpa_pkg::alu_req_t areq,
  output logic [W-1:0]       opa,
  output logic [W-1:0]       opb,
  input  logic [W-1:0]       ares,
  input  ecpa_pkg::op_stat_t astat,
  output logic [W-1:0]       rx,
  output logic [W-1:0]       ry,
  output logic               rinf,
  output ecpa_pkg::op_stat_t stat
);
  import ecpa_pkg::*;

  localparam logic [1:0] P_IDLE  = 2'd0;
  localparam logic [1:0] P_ISSUE = 2'd1;
  localparam logic [1:0] P_WAIT  = 2'd2;

  localparam logic [3:0] PC_SUM  = 4'd0;
  localparam logic [3:0] PC_NUMS = 4'd1;
  localparam logic [3:0] PC_DENS = 4'd2;
  localparam logic [3:0] PC_SQ   = 4'd3;
  localparam logic [3:0] PC_TW   = 4'd4;
  localparam logic [3:0] PC_TH   = 4'd5;
  localparam logic [3:0] PC_PA   = 4'd6;
  localparam logic [3:0] PC_DEND = 4'd7;
  localparam logic [3:0] PC_INV  = 4'd8;
  localparam logic [3:0] PC_SLP  = 4'd9;
  localparam logic [3:0] PC_SS   = 4'd10;
  localparam logic [3:0] PC_X1   = 4'd11;
  localparam logic [3:0] PC_X3   = 4'd12;
  localparam logic [3:0] PC_DX   = 4'd13;
  localparam logic [3:0] PC_YM   = 4'd14;
  localparam logic [3:0] PC_Y3   = 4'd15;

  logic [1:0]   st;
  logic [3:0]   pc, pc_next;
  logic [1:0]   op;
  logic [W-1:0] tmp, num, den, x3;
  logic         done, fail, done_next;

  // step table: num holds the slope once it is known
  always_comb begin
    op  = ALU_ADD;
    opa = '0;
    opb = '0;
    unique case (pc)
      PC_SUM:  begin op = ALU_ADD; opa = uy;  opb = vy;  end
      PC_NUMS: begin op = ALU_SUB; opa = vy;  opb = uy;  end
      PC_DENS: begin op = ALU_SUB; opa = vx;  opb = ux;  end
      PC_SQ:   begin op = ALU_MUL; opa = ux;  opb = ux;  end
      PC_TW:   begin op = ALU_ADD; opa = tmp; opb = tmp; end
      PC_TH:   begin op = ALU_ADD; opa = num; opb = tmp; end
      PC_PA:   begin op = ALU_ADD; opa = num; opb = ca;  end
      PC_DEND: begin op = ALU_ADD; opa = uy;  opb = uy;  end
      PC_INV:  begin op = ALU_INV; opa = den; opb = '0;  end
      PC_SLP:  begin op = ALU_MUL; opa = num; opb = den; end
      PC_SS:   begin op = ALU_MUL; opa = num; opb = num; end
      PC_X1:   begin op = ALU_SUB; opa = tmp; opb = ux;  end
      PC_X3:   begin op = ALU_SUB; opa = tmp; opb = vx;  end
      PC_DX:   begin op = ALU_SUB; opa = ux;  opb = x3;  end
      PC_YM:   begin op = ALU_MUL; opa = num; opb = tmp; end
      PC_Y3:   begin op = ALU_SUB; opa = tmp; opb = uy;  end
    endcase
  end

  // next step and end of the operation
  always_comb begin
    pc_next = pc + 1'b1;
    if (pc == PC_SUM) pc_next = (ux != vx) ? PC_NUMS : PC_SQ;
    else if (pc == PC_DENS) pc_next = PC_INV;
    done_next = 1'b0;
    if (st == P_IDLE) begin
      done_next = start && (uinf || vinf);
    end else if (st == P_WAIT && astat.done) begin
      // opposite points, including doubling with y of zero
      done_next = ((pc == PC_SUM) && (ux == vx) && (ares == '0))
               || ((pc == PC_INV) && astat.fail)
               || (pc == PC_Y3);
    end
  end

  assign areq.start = (st == P_ISSUE);
  assign areq.op    = op;

  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= P_IDLE;
      done <= 1'b0;
    end else begin
      done <= done_next;
      unique case (st)
        P_IDLE: begin
          if (start) begin
            fail <= 1'b0;
            if (uinf) begin
              rx   <= vx;
              ry   <= vy;
              rinf <= vinf;
            end else if (vinf) begin
              rx   <= ux;
              ry   <= uy;
              rinf <= 1'b0;
            end else begin
              pc <= PC_SUM;
              st <= P_ISSUE;
            end
          end
        end
        P_ISSUE: st <= P_WAIT;
        P_WAIT: begin
          if (astat.done) begin
            st <= done_next ? P_IDLE : P_ISSUE;
            pc <= pc_next;
            unique case (pc)
              PC_SUM: begin
                tmp <= ares;
                if (ux == vx && ares == '0) rinf <= 1'b1;
              end
              PC_NUMS: num <= ares;
              PC_DENS: den <= ares;
              PC_SQ:   tmp <= ares;
              PC_TW:   num <= ares;
              PC_TH:   num <= ares;
              PC_PA:   num <= ares;
              PC_DEND: den <= ares;
              PC_INV: begin
                den <= ares;
                if (astat.fail) begin
                  fail <= 1'b1;
                  rinf <= 1'b1;
                end
              end
              PC_SLP:  num <= ares;
              PC_SS:   tmp <= ares;
              PC_X1:   tmp <= ares;
              PC_X3:   x3  <= ares;
              PC_DX:   tmp <= ares;
              PC_YM:   tmp <= ares;
              PC_Y3: begin
                rx   <= x3;
                ry   <= ares;
                rinf <= 1'b0;
              end
            endcase
          end
        end
        default: st <= P_IDLE;
      endcase
    end
  end

  assign stat.done = done;
  assign stat.fail = fail;

endmodule

// ----- verif/testbench.sv -----
// self-checking testbench for ecc_point_arithmetic_top: random and directed point operations
// predicts each result with its own modular arithmetic; depends on ecpa_pkg and the rtl
module testbench;
  import ecpa_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] x1, y1, x2, y2, scalar;
    logic        inf1, inf2;
  } op_item_t;

  typedef struct {
    logic [31:0] rx, ry;
    logic        rinf, fail;
  } point_res_t;

  typedef struct {
    u64_t x, y;
    bit   inf;
  } point_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [OUT_USER_W-1:0] m_axis_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  op_item_t   pending_ops[$];
  point_res_t expected_points[$];
  u64_t       prime_shadow = 23;
  u64_t       a_shadow = 1;
  bit         inv_fail;
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         long_hold = 1'b0;
  int         held_cycles = 0;
  logic       in_fire = 1'b0;

  ecc_point_arithmetic_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic u64_t fadd(u64_t a, u64_t b, u64_t p);
    return (a >= p - b) ? a - (p - b) : a + b;
  endfunction

  function automatic u64_t fsub(u64_t a, u64_t b, u64_t p);
    return (a >= b) ? a - b : a + (p - b);
  endfunction

  // operands are below p < 2^32, so the product fits
  function automatic u64_t fmul(u64_t a, u64_t b, u64_t p);
    return (a * b) % p;
  endfunction

  function automatic u64_t finv(u64_t a, u64_t p);
    u64_t r0 = p, r1 = a, t0 = 0, t1 = 1, q, tmp;
    while (r1 != 0) begin
      q = r0 / r1;
      tmp = r0 - q * r1;
      r0 = r1;
      r1 = tmp;
      tmp = fsub(t0, fmul(q % p, t1, p), p);
      t0 = t1;
      t1 = tmp;
    end
    if (r0 != 1) begin
      inv_fail = 1'b1;
      return 0;
    end
    return t0;
  endfunction

  function automatic point_t point_sum(point_t u, point_t v, u64_t a, u64_t p);
    point_t r = '{0, 0, 1'b1};
    u64_t num, den, s, x3, y3;
    if (inv_fail) return r;
    if (u.inf) return v;
    if (v.inf) return u;
    if (u.x == v.x && fadd(u.y, v.y, p) == 0) return r;
    if (u.x != v.x) begin
      num = fsub(v.y, u.y, p);
      den = fsub(v.x, u.x, p);
    end else begin
      num = fadd(fmul(3 % p, fmul(u.x, u.x, p), p), a, p);
      den = fmul(2 % p, u.y, p);
    end
    s = fmul(num, finv(den, p), p);
    if (inv_fail) return r;
    x3 = fsub(fsub(fmul(s, s, p), u.x, p), v.x, p);
    y3 = fsub(fmul(s, fsub(u.x, x3, p), p), u.y, p);
    r.x = x3;
    r.y = y3;
    r.inf = 1'b0;
    return r;
  endfunction

  function automatic point_res_t compute_point(op_item_t it);
    point_res_t res;
    point_t u, v, r = '{0, 0, 1'b1};
    u64_t p = prime_shadow, a, k;
    inv_fail = 1'b0;
    if (p < 2) begin
      inv_fail = 1'b1;
    end else begin
      a = a_shadow % p;
      u = '{u64_t'(it.x1) % p, u64_t'(it.y1) % p, it.inf1};
      v = '{u64_t'(it.x2) % p, u64_t'(it.y2) % p, it.inf2};
      case (it.action)
        ACT_MUL: begin
          k = it.scalar;
          while (k != 0 && !inv_fail) begin
            if (k[0]) r = point_sum(r, u, a, p);
            k = k >> 1;
            if (k != 0) u = point_sum(u, u, a, p);
          end
        end
        ACT_ADD: r = point_sum(u, v, a, p);
        ACT_SUB: begin
          v.y = fsub(0, v.y, p);
          r = point_sum(u, v, a, p);
        end
        default: ;
      endcase
    end
    if (inv_fail || r.inf) r = '{0, 0, 1'b1};
    res.rx = r.x[31:0];
    res.ry = r.y[31:0];
    res.rinf = r.inf;
    res.fail = inv_fail;
    return res;
  endfunction

  function automatic logic [31:0] rand_coord(u64_t p);
    if (p < 2 || $urandom_range(99) < 30) return $urandom;
    return 32'($urandom % p);
  endfunction

  // often related operand pairs so that doubling and opposite points come up often
  function automatic op_item_t rand_op(u64_t p);
    op_item_t it;
    int sel;
    it.action = ($urandom_range(99) < 3) ? 2'd3 : 2'($urandom_range(0, 2));
    it.x1 = rand_coord(p);
    it.y1 = rand_coord(p);
    it.x2 = ($urandom_range(99) < 25) ? it.x1 : rand_coord(p);
    sel = $urandom_range(2);
    if (sel == 0) it.y2 = it.y1;
    else if (sel == 1 && p >= 2) it.y2 = 32'(fsub(0, u64_t'(it.y1) % p, p));
    else it.y2 = rand_coord(p);
    it.inf1 = ($urandom_range(99) < 10);
    it.inf2 = ($urandom_range(99) < 10);
    it.scalar = ($urandom_range(99) < 85) ? 32'($urandom_range(0, 300)) : $urandom;
    return it;
  endfunction

  function automatic op_item_t mk_op(logic [1:0] act, logic [31:0] x1, logic [31:0] y1,
                                     logic i1, logic [31:0] x2, logic [31:0] y2, logic i2,
                                     logic [31:0] k);
    op_item_t it;
    it = '{act, x1, y1, x2, y2, k, i1, i2};
    return it;
  endfunction

  // input side: sample handshake at the rising edge, drive at the falling edge
  always @(posedge clk) begin
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      op_item_t it;
      it.x1 = s_axis_tdata[31:0];
      it.y1 = s_axis_tdata[63:32];
      it.x2 = s_axis_tdata[95:64];
      it.y2 = s_axis_tdata[127:96];
      it.scalar = s_axis_tdata[159:128];
      it.action = s_axis_tuser[1:0];
      it.inf1 = s_axis_tuser[2];
      it.inf2 = s_axis_tuser[3];
      expected_points.push_back(compute_point(it));
    end
  end

  always @(negedge clk) begin
    op_item_t it;
    if (!rst && (!s_axis_tvalid || in_fire)) begin
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        it = pending_ops.pop_front();
        s_axis_tdata <= {it.scalar, it.y2, it.x2, it.y1, it.x1};
        s_axis_tuser <= {it.inf2, it.inf1, it.action};
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (long_hold && held_cycles < 20000) begin
      held_cycles <= held_cycles + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      point_res_t want;
      if (expected_points.size() == 0) begin
        $error("result transaction with no expected point");
        fail_count++;
      end else begin
        want = expected_points.pop_front();
        if (m_axis_tdata[31:0] !== want.rx) begin
          $error("result_x: expected %h actual %h", want.rx, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[63:32] !== want.ry) begin
          $error("result_y: expected %h actual %h", want.ry, m_axis_tdata[63:32]);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.rinf) begin
          $error("result_is_infinity: expected %b actual %b", want.rinf, m_axis_tuser[0]);
          fail_count++;
        end
        if (m_axis_tuser[1] !== want.fail) begin
          $error("inverse_failed: expected %b actual %b", want.fail, m_axis_tuser[1]);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_ops.size() != 0 || s_axis_tvalid || expected_points.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_PRIME) prime_shadow = val;
    else a_shadow = val;
  endtask

  // random items in chunks, each chunk with its own idling mode
  task automatic run_random(int count);
    for (int i = 0; i < count; i++) begin
      case ((i / 8) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      pending_ops.push_back(rand_op(prime_shadow));
      while (pending_ops.size() > 2) @(posedge clk);
    end
    wait_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset setting, p = 23, a = 1
    pending_ops.push_back(mk_op(ACT_ADD, 5, 7, 1, 3, 10, 0, 0));
    pending_ops.push_back(mk_op(ACT_ADD, 5, 7, 0, 3, 10, 1, 0));
    pending_ops.push_back(mk_op(ACT_SUB, 5, 7, 1, 3, 10, 1, 0));
    pending_ops.push_back(mk_op(ACT_ADD, 9, 4, 0, 9, 19, 0, 0));
    pending_ops.push_back(mk_op(ACT_ADD, 6, 0, 0, 6, 0, 0, 0));
    pending_ops.push_back(mk_op(ACT_ADD, 3, 10, 0, 3, 10, 0, 0));
    pending_ops.push_back(mk_op(ACT_SUB, 3, 10, 0, 3, 10, 0, 0));
    pending_ops.push_back(mk_op(ACT_MUL, 3, 10, 0, 0, 0, 0, 0));
    pending_ops.push_back(mk_op(ACT_MUL, 3, 10, 0, 0, 0, 0, 1));
    pending_ops.push_back(mk_op(ACT_MUL, 3, 10, 0, 0, 0, 0, 32'hFFFF_FFFF));
    pending_ops.push_back(mk_op(ACT_MUL, 3, 10, 1, 0, 0, 0, 12));
    pending_ops.push_back(mk_op(2'd3, 3, 10, 0, 9, 4, 0, 5));
    pending_ops.push_back(mk_op(ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                                32'hFFFF_FFFF, 32'h0, 0, 32'hFFFF_FFFF));
    pending_ops.push_back(mk_op(ACT_SUB, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    wait_drained();
    run_random(20);

    write_reg(REG_PRIME, 97);
    write_reg(REG_A, 2);
    // long hold on the result side while items keep coming
    long_hold = 1'b1;
    for (int i = 0; i < 4; i++) pending_ops.push_back(rand_op(97));
    wait_drained();
    long_hold = 1'b0;
    run_random(20);

    write_reg(REG_PRIME, 32'hFFFF_FFFB);
    write_reg(REG_A, 32'hFFFF_FFFE);
    pending_ops.push_back(mk_op(ACT_MUL, 32'h1234_5678, 32'h9ABC_DEF0, 0, 0, 0, 0,
                                32'hFFFF_FFFF));
    pending_ops.push_back(mk_op(ACT_MUL, 32'hFFFF_FFFF, 1, 0, 0, 0, 0, 32'h8000_0001));
    wait_drained();
    run_random(30);

    write_reg(REG_PRIME, 3);
    write_reg(REG_A, 0);
    run_random(15);

    write_reg(REG_PRIME, 15);
    write_reg(REG_A, 7);
    pending_ops.push_back(mk_op(ACT_ADD, 4, 5, 0, 4, 5, 0, 0));
    pending_ops.push_back(mk_op(ACT_ADD, 1, 2, 0, 4, 2, 0, 0));
    wait_drained();
    run_random(15);

    write_reg(REG_PRIME, 0);
    write_reg(REG_A, 0);
    run_random(5);

    write_reg(REG_PRIME, 1);
    run_random(5);

    write_reg(REG_PRIME, 32'hFFFF_FFFF);
    write_reg(REG_A, 32'hFFFF_FFFE);
    run_random(20);

    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
